/* hdl/rbst_pkg.sv */
// Shared constants and types for the ray-box slab test pipeline.
package rbst_pkg;

    localparam int QW          = 32;            // Q16.16 word width
    localparam int FW          = 16;            // fraction bits
    localparam int NUM_W       = QW + 1 + FW;   // |corner - origin| scaled by 2^16
    localparam int DIV_BITS    = 4;             // quotient bits per divider stage
    localparam int DIV_STAGES  = QW / DIV_BITS; // compute stages in a divider lane
    localparam int TW          = QW + 2;        // enter/exit width, holds unbounded marks
    localparam int NAXES       = 3;
    localparam int NCFG        = 8;
    localparam int CFG_IDX_W   = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_T_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd7;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // Bounds beyond any saturated quotient
    localparam logic signed [TW-1:0] T_NEG_UNB = -(34'sd1 <<< QW);
    localparam logic signed [TW-1:0] T_POS_UNB =  (34'sd1 <<< QW);

    // One divider lane operand: magnitude of the scaled numerator and quotient sign
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
    } t_div_op;

endpackage

/* hdl/rbst_div_lane.sv */
// Pipelined restoring divider lane with signed Q16.16 saturation.
module rbst_div_lane
    import rbst_pkg::*;
(
    input  logic                        i_clk,
    input  logic [DIV_STAGES:0]         i_en,     // per-stage load enables
    input  t_div_op                     i_op,
    input  logic [QW-1:0]               i_dabs,   // |direction|, must be held constant; the lane does not enforce it
    output logic signed [QW-1:0]        o_quot
);

    logic [QW-1:0] r_rem  [0:DIV_STAGES];
    logic [QW-1:0] r_low  [0:DIV_STAGES];
    logic [QW-1:0] r_q    [0:DIV_STAGES];
    logic          r_ovf  [0:DIV_STAGES];
    logic          r_neg  [0:DIV_STAGES];

    logic [QW:0]   w_dabs;
    assign w_dabs = {1'b0, i_dabs};

    // Load operand; quotient of 2^32 or more saturates regardless of the rest
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ovf[0] <= ({{(2*QW - NUM_W + 1){1'b0}}, i_op.num[NUM_W-1:QW]} >= w_dabs);
            r_rem[0] <= {{(2*QW - NUM_W){1'b0}}, i_op.num[NUM_W-1:QW]};
            r_low[0] <= i_op.num[QW-1:0];
            r_q[0]   <= '0;
            r_neg[0] <= i_op.neg;
        end
    end

    // Develop DIV_BITS quotient bits per stage
    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_stage
        logic [QW-1:0] n_rem, n_low, n_q;
        logic [QW:0]   w_try;

        always_comb begin
            n_rem = r_rem[s-1];
            n_low = r_low[s-1];
            n_q   = r_q[s-1];
            w_try = '0;
            for (int b = 0; b < DIV_BITS; b++) begin
                w_try = {n_rem, n_low[QW-1]};
                n_low = {n_low[QW-2:0], 1'b0};
                if (w_try >= w_dabs) begin
                    n_rem = QW'(w_try - w_dabs);
                    n_q   = {n_q[QW-2:0], 1'b1};
                end else begin
                    n_rem = w_try[QW-1:0];
                    n_q   = {n_q[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem;
                r_low[s] <= n_low;
                r_q[s]   <= n_q;
                r_ovf[s] <= r_ovf[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    // Apply sign and clamp to the signed 32-bit range
    always_comb begin
        if (r_neg[DIV_STAGES]) begin
            if (r_ovf[DIV_STAGES] || r_q[DIV_STAGES] > 32'h8000_0000)
                o_quot = Q_MIN;
            else
                o_quot = $signed(32'd0 - r_q[DIV_STAGES]);
        end else begin
            if (r_ovf[DIV_STAGES] || r_q[DIV_STAGES][QW-1])
                o_quot = Q_MAX;
            else
                o_quot = $signed(r_q[DIV_STAGES]);
        end
    end

endmodule

/* hdl/ray_box_slab_test.sv */
// Top level of the ray against axis-aligned box slab test.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  box in  | slave     | i_s_tvalid/o_s_tready  | i_s_tdata: lo_x,lo_y,lo_z,hi_x,hi_y,hi_z
//  hit out | master    | o_m_tvalid/i_m_tready  | o_m_tdata[0]: hit, bits 7:1 zero
//  config  | write     | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One box enters per cycle unless the output stalls.
// Most of the pipe is the six divider lanes: a load stage and 8 stages of 4 quotient bits.
// Reset is synchronous, active low; it empties the pipe and loads the default ray.
// Each stage holds only when it is full and the stage after it holds, so bubbles close up.
module ray_box_slab_test
    import rbst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [6*QW-1:0]       i_s_tdata,   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // hit, zero fill
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [QW-1:0]         i_cfg_data
);

    localparam int ST_LANE = 1;                    // first lane register stage
    localparam int ST_TNF  = ST_LANE + DIV_STAGES + 1;
    localparam int ST_EE   = ST_TNF + 1;
    localparam int ST_OUT  = ST_EE + 1;
    localparam int NST     = ST_OUT + 1;

    // Configuration registers
    logic signed [QW-1:0] r_org [NAXES];
    logic signed [QW-1:0] r_dir [NAXES];
    logic [QW-2:0]        r_tlim;
    logic [FW-1:0]        r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= 32'sh0001_0000;
            r_dir[1] <= '0;
            r_dir[2] <= '0;
            r_tlim   <= '1;
            r_eps    <= 16'd66;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                REG_DIR_X:    r_dir[0] <= i_cfg_data;
                REG_DIR_Y:    r_dir[1] <= i_cfg_data;
                REG_DIR_Z:    r_dir[2] <= i_cfg_data;
                REG_T_LIMIT:  r_tlim   <= i_cfg_data[QW-2:0];
                REG_EPSILON:  r_eps    <= i_cfg_data[FW-1:0];
                default:      ;
            endcase
        end
    end

    // Per-stage valid bits and load enables
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_m_tready;
        for (int k = NST - 2; k >= 0; k--)
            w_en[k] = !r_vld[k] || w_en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0])
                r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NST; k++)
                if (w_en[k])
                    r_vld[k] <= r_vld[k-1];
        end
    end

    assign o_s_tready = w_en[0];

    // Capture box transaction
    logic signed [QW-1:0] r_lo [NAXES];
    logic signed [QW-1:0] r_hi [NAXES];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int a = 0; a < NAXES; a++) begin
                r_lo[a] <= i_s_tdata[a*QW +: QW];
                r_hi[a] <= i_s_tdata[(a+NAXES)*QW +: QW];
            end
        end
    end

    // Form divider operands and the zero-direction miss flag
    logic [NAXES-1:0]  w_dzero;
    logic [QW-1:0]     w_dabs [NAXES];
    t_div_op           w_op   [2*NAXES];
    logic              w_miss;

    always_comb begin
        logic signed [QW:0] v_diff;
        logic [QW:0]        v_mag;
        w_miss = 1'b0;
        for (int a = 0; a < NAXES; a++) begin
            w_dzero[a] = (r_dir[a] == '0);
            w_dabs[a]  = r_dir[a][QW-1] ? 32'd0 - r_dir[a] : r_dir[a];
            if (w_dzero[a] && !(r_lo[a] <= r_org[a] && r_org[a] <= r_hi[a]))
                w_miss = 1'b1;
            for (int c = 0; c < 2; c++) begin
                v_diff = (c == 0) ? ({r_lo[a][QW-1], r_lo[a]} - {r_org[a][QW-1], r_org[a]})
                                  : ({r_hi[a][QW-1], r_hi[a]} - {r_org[a][QW-1], r_org[a]});
                v_mag  = v_diff[QW] ? (QW+1)'(0) - v_diff : v_diff;
                w_op[a*2+c].num = {v_mag, {FW{1'b0}}};
                w_op[a*2+c].neg = v_diff[QW] ^ r_dir[a][QW-1];
            end
        end
    end

    // Carry the miss flag beside the lanes
    logic r_miss [ST_LANE:ST_EE];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_LANE])
            r_miss[ST_LANE] <= w_miss;
        for (int k = ST_LANE + 1; k <= ST_EE; k++)
            if (w_en[k])
                r_miss[k] <= r_miss[k-1];
    end

    // Six divider lanes, two corners per axis
    logic signed [QW-1:0] w_quot [2*NAXES];

    for (genvar l = 0; l < 2*NAXES; l++) begin : g_lane
        rbst_div_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en[ST_LANE +: DIV_STAGES+1]),
            .i_op   (w_op[l]),
            .i_dabs (w_dabs[l/2]),
            .o_quot (w_quot[l])
        );
    end

    // Order each pair into near and far
    logic signed [QW-1:0] r_tn [NAXES];
    logic signed [QW-1:0] r_tf [NAXES];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_TNF]) begin
            for (int a = 0; a < NAXES; a++) begin
                if (w_quot[2*a] < w_quot[2*a+1]) begin
                    r_tn[a] <= w_quot[2*a];
                    r_tf[a] <= w_quot[2*a+1];
                end else begin
                    r_tn[a] <= w_quot[2*a+1];
                    r_tf[a] <= w_quot[2*a];
                end
            end
        end
    end

    // Reduce to enter and exit, skipping unbounded slabs
    logic signed [TW-1:0] r_enter, r_exit;
    logic signed [TW-1:0] n_enter, n_exit;

    always_comb begin
        n_enter = T_NEG_UNB;
        n_exit  = T_POS_UNB;
        for (int a = 0; a < NAXES; a++) begin
            if (!w_dzero[a]) begin
                if (TW'(r_tn[a]) > n_enter) n_enter = TW'(r_tn[a]);
                if (TW'(r_tf[a]) < n_exit)  n_exit  = TW'(r_tf[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_EE]) begin
            r_enter <= n_enter;
            r_exit  <= n_exit;
        end
    end

    // Final compare into the output register
    logic r_hit;
    logic signed [TW:0] w_enter_eps;
    assign w_enter_eps = (TW+1)'(r_enter) - $signed({{(TW-FW+1){1'b0}}, r_eps});

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT])
            r_hit <= !r_miss[ST_EE]
                     && (r_exit > 0)
                     && ((TW+1)'(r_exit) > w_enter_eps)
                     && (r_enter < $signed({{(TW-QW+1){1'b0}}, r_tlim}));
    end

    assign o_m_tvalid = r_vld[ST_OUT];
    assign o_m_tdata  = {7'd0, r_hit};

    // Checks
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted box did not enter the pipe");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_vld[0] && o_m_tvalid && !i_m_tready)
        else $error("input stalled with room in the pipe");

    a_miss_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en[ST_OUT] && r_vld[ST_EE] && r_miss[ST_EE] |=> o_m_tvalid && !o_m_tdata[0])
        else $error("hit reported for a box missed on a zero-direction axis");

endmodule
